@@ src/bsc_pkg.sv @@
// shared types, constants and helpers for the pressure compensation block
package bsc_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_A = 3'd0,
    REG_COEFF_B = 3'd1,
    REG_COEFF_C = 3'd2,
    REG_COEFF_D = 3'd3,
    REG_OSS     = 3'd4
  } cfg_reg_t;

  localparam int CFG_DATA_W = 48;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_TAG_W  = 66;

  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] B4_OFFSET  = 32'd32768;
  localparam logic [31:0] B7_SCALE   = 32'd50000;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] POLY_K1    = 32'd3038;
  localparam logic [31:0] POLY_K2    = 32'hFFFF_E343;
  localparam logic [31:0] POLY_K3    = 32'd3791;
  localparam logic [19:0] P_MAX      = 20'hF_FFFF;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure_bytes;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [19:0]        pressure_pa;
    logic               divide_fault;
  } out_word_t;

  typedef struct packed {
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [1:0]  oss;
  } coeff_t;

  // low 32 bits of a product
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

@@ src/bsc_divider.sv @@
// pipelined 32-bit restoring unsigned divider, one quotient bit per stage
module bsc_divider
  import bsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_v,
  input  logic [31:0]          in_num,
  input  logic [31:0]          in_den,
  input  logic [DIV_TAG_W-1:0] in_tag,
  output logic                 out_v,
  output logic [31:0]          out_quo,
  output logic [DIV_TAG_W-1:0] out_tag
);

  logic [DIV_STEPS-1:0] v_r;
  logic [31:0]          rem_r [DIV_STEPS];
  logic [31:0]          quo_r [DIV_STEPS];
  logic [31:0]          den_r [DIV_STEPS];
  logic [DIV_TAG_W-1:0] tag_r [DIV_STEPS];
  logic [31:0]          rem_nxt [DIV_STEPS];
  logic [31:0]          quo_nxt [DIV_STEPS];

  always_comb begin
    logic [32:0] sh;
    logic [32:0] df;
    logic [31:0] rem_i, quo_i, den_i;
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (s == 0) begin
        rem_i = '0;
        quo_i = in_num;
        den_i = in_den;
      end else begin
        rem_i = rem_r[s-1];
        quo_i = quo_r[s-1];
        den_i = den_r[s-1];
      end
      sh = {rem_i, quo_i[31]};
      df = sh - {1'b0, den_i};
      if (!df[32]) begin
        rem_nxt[s] = df[31:0];
        quo_nxt[s] = {quo_i[30:0], 1'b1};
      end else begin
        rem_nxt[s] = sh[31:0];
        quo_nxt[s] = {quo_i[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DIV_STEPS-2:0], in_v};
    end
    if (adv) begin
      rem_r    <= rem_nxt;
      quo_r    <= quo_nxt;
      den_r[0] <= in_den;
      tag_r[0] <= in_tag;
      for (int s = 1; s < DIV_STEPS; s++) begin
        den_r[s] <= den_r[s-1];
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  assign out_v   = v_r[DIV_STEPS-1];
  assign out_quo = quo_r[DIV_STEPS-1];
  assign out_tag = tag_r[DIV_STEPS-1];

endmodule

@@ src/baro_sensor_compensation_top.sv @@
// pressure sensor compensation: pipelined temperature and pressure datapath
// path: stages 1-2, temperature divider, stages 3-7, pressure divider, stages 8-9, output register
// throughput: one word per cycle when not stalled; two 32-stage dividers set the pipeline depth
// an output stall with out_valid high freezes the whole pipeline; out register doubles as the last stage
// reset (synchronous, rst_n low) clears all valid bits and coefficient registers to zero
module baro_sensor_compensation_top
  import bsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [47:0] grp_a_r, grp_b_r;
  logic [31:0] grp_c_r, grp_d_r;
  logic [1:0]  oss_r;
  coeff_t      k;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_a_r <= '0;
      grp_b_r <= '0;
      grp_c_r <= '0;
      grp_d_r <= '0;
      oss_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COEFF_A: grp_a_r <= cfg_data;
        REG_COEFF_B: grp_b_r <= cfg_data;
        REG_COEFF_C: grp_c_r <= cfg_data[31:0];
        REG_COEFF_D: grp_d_r <= cfg_data[31:0];
        REG_OSS:     oss_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    k.ac1 = sx16(grp_a_r[47:32]);
    k.ac2 = sx16(grp_a_r[31:16]);
    k.ac3 = sx16(grp_a_r[15:0]);
    k.ac4 = {16'd0, grp_b_r[47:32]};
    k.ac5 = {16'd0, grp_b_r[31:16]};
    k.ac6 = {16'd0, grp_b_r[15:0]};
    k.b1  = sx16(grp_c_r[31:16]);
    k.b2  = sx16(grp_c_r[15:0]);
    k.mc  = sx16(grp_d_r[31:16]);
    k.md  = sx16(grp_d_r[15:0]);
    k.oss = oss_r;
  end

  // whole pipeline advances together
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: x1 product
  logic        s1_v_r;
  logic [31:0] s1_prod_r, s1_up_r;
  logic [31:0] up_w;
  assign up_w = {8'd0, in_data.raw_pressure_bytes} >> (4'd8 - {2'd0, k.oss});
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_valid;
    if (adv) begin
      s1_prod_r <= mul32({16'd0, in_data.raw_temperature} - k.ac6, k.ac5);
      s1_up_r   <= up_w;
    end
  end

  // stage 2: x1, divisor, numerator sign handling
  logic        s2_v_r;
  logic [31:0] s2_x1_r, s2_up_r, s2_div_r;
  logic [31:0] x1t, divt, numt;
  always_comb begin
    x1t  = asr32(s1_prod_r, 5'd15);
    divt = x1t + k.md;
    numt = mul32(k.mc, 32'd2048);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
    if (adv) begin
      s2_x1_r  <= x1t;
      s2_up_r  <= s1_up_r;
      s2_div_r <= divt;
    end
  end

  // temperature divider: magnitude division, tag carries x1, up, result sign, fault
  logic [31:0] nmag, dmag;
  logic        tneg, tfault;
  always_comb begin
    nmag   = numt[31] ? (32'd0 - numt) : numt;
    dmag   = s2_div_r[31] ? (32'd0 - s2_div_r) : s2_div_r;
    tneg   = numt[31] ^ s2_div_r[31];
    tfault = (s2_div_r == 32'd0);
  end
  logic                 d1_v;
  logic [31:0]          d1_q;
  logic [DIV_TAG_W-1:0] d1_tag;
  bsc_divider u_tdiv (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_v(s2_v_r), .in_num(nmag), .in_den(tfault ? 32'd1 : dmag),
    .in_tag({s2_x1_r, s2_up_r, tneg, tfault}),
    .out_v(d1_v), .out_quo(d1_q), .out_tag(d1_tag)
  );

  // stage 3: b5, b6, temperature
  logic        s3_v_r, s3_flt_r;
  logic [31:0] s3_b6_r, s3_up_r;
  logic [15:0] s3_t_r;
  logic [31:0] x2t, b5t, tw;
  logic [15:0] tsat;
  always_comb begin
    x2t = d1_tag[1] ? (32'd0 - d1_q) : d1_q;
    b5t = d1_tag[DIV_TAG_W-1 -: 32] + x2t;
    tw  = asr32(b5t + 32'd8, 5'd4);
    if ($signed(tw) > 32'sd32767) tsat = 16'h7FFF;
    else if ($signed(tw) < -32'sd32768) tsat = 16'h8000;
    else tsat = tw[15:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= d1_v;
    if (adv) begin
      s3_b6_r  <= b5t - B6_OFFSET;
      s3_up_r  <= d1_tag[33:2];
      s3_t_r   <= tsat;
      s3_flt_r <= d1_tag[0];
    end
  end

  // stage 4: b6 squared, ac2*b6, ac3*b6
  logic        s4_v_r, s4_flt_r;
  logic [31:0] s4_sq_r, s4_a2_r, s4_a3_r, s4_up_r;
  logic [15:0] s4_t_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
    if (adv) begin
      s4_sq_r  <= mul32(s3_b6_r, s3_b6_r);
      s4_a2_r  <= mul32(k.ac2, s3_b6_r);
      s4_a3_r  <= mul32(k.ac3, s3_b6_r);
      s4_up_r  <= s3_up_r;
      s4_t_r   <= s3_t_r;
      s4_flt_r <= s3_flt_r;
    end
  end

  // stage 5: b2*b6sq, b1*b6sq
  logic        s5_v_r, s5_flt_r;
  logic [31:0] s5_p2_r, s5_p1_r, s5_a2_r, s5_a3_r, s5_up_r;
  logic [15:0] s5_t_r;
  logic [31:0] b6sq;
  assign b6sq = asr32(s4_sq_r, 5'd12);
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= s4_v_r;
    if (adv) begin
      s5_p2_r  <= mul32(k.b2, b6sq);
      s5_p1_r  <= mul32(k.b1, b6sq);
      s5_a2_r  <= s4_a2_r;
      s5_a3_r  <= s4_a3_r;
      s5_up_r  <= s4_up_r;
      s5_t_r   <= s4_t_r;
      s5_flt_r <= s4_flt_r;
    end
  end

  // stage 6: b3 and x3 for b4
  logic        s6_v_r, s6_flt_r;
  logic [31:0] s6_b3_r, s6_x3_r, s6_up_r;
  logic [15:0] s6_t_r;
  logic [31:0] b3t, x3a, x3b;
  always_comb begin
    x3a = asr32(s5_p2_r, 5'd11) + asr32(s5_a2_r, 5'd11);
    b3t = asr32(((mul32(k.ac1, 32'd4) + x3a) << k.oss) + 32'd2, 5'd2);
    x3b = asr32(asr32(s5_a3_r, 5'd13) + asr32(s5_p1_r, 5'd16) + 32'd2, 5'd2);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (adv) s6_v_r <= s5_v_r;
    if (adv) begin
      s6_b3_r  <= b3t;
      s6_x3_r  <= x3b + B4_OFFSET;
      s6_up_r  <= s5_up_r;
      s6_t_r   <= s5_t_r;
      s6_flt_r <= s5_flt_r;
    end
  end

  // stage 7: b4 product and b7
  logic        s7_v_r, s7_flt_r;
  logic [31:0] s7_b4p_r, s7_b7_r;
  logic [15:0] s7_t_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (adv) s7_v_r <= s6_v_r;
    if (adv) begin
      s7_b4p_r <= mul32(k.ac4, s6_x3_r);
      s7_b7_r  <= mul32(s6_up_r - s6_b3_r, B7_SCALE >> k.oss);
      s7_t_r   <= s6_t_r;
      s7_flt_r <= s6_flt_r;
    end
  end

  // pressure divider
  localparam int PT_W = 16 + 1 + 1;
  logic [31:0] b4t, pnum;
  logic        plo, pflt;
  always_comb begin
    b4t  = s7_b4p_r >> 15;
    plo  = (s7_b7_r < SIGN_BIT);
    pnum = plo ? (s7_b7_r << 1) : s7_b7_r;
    pflt = s7_flt_r || (b4t == 32'd0);
  end
  logic                 d2_v;
  logic [31:0]          d2_q;
  logic [DIV_TAG_W-1:0] d2_tag;
  bsc_divider u_pdiv (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_v(s7_v_r), .in_num(pnum), .in_den(pflt ? 32'd1 : b4t),
    .in_tag({{(DIV_TAG_W-PT_W){1'b0}}, s7_t_r, plo, pflt}),
    .out_v(d2_v), .out_quo(d2_q), .out_tag(d2_tag)
  );

  // stage 8: p, polynomial products
  logic        s8_v_r, s8_flt_r;
  logic [31:0] s8_p_r, s8_sq_r, s8_k2_r;
  logic [15:0] s8_t_r;
  logic [31:0] pt, pe;
  always_comb begin
    pt = d2_tag[1] ? d2_q : (d2_q << 1);
    pe = asr32(pt, 5'd8);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s8_v_r <= 1'b0;
    else if (adv) s8_v_r <= d2_v;
    if (adv) begin
      s8_p_r   <= pt;
      s8_sq_r  <= mul32(pe, pe);
      s8_k2_r  <= mul32(POLY_K2, pt);
      s8_t_r   <= d2_tag[PT_W-1 -: 16];
      s8_flt_r <= d2_tag[0];
    end
  end

  // stage 9: 3038 product
  logic        s9_v_r, s9_flt_r;
  logic [31:0] s9_p_r, s9_k1_r, s9_k2_r;
  logic [15:0] s9_t_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s9_v_r <= 1'b0;
    else if (adv) s9_v_r <= s8_v_r;
    if (adv) begin
      s9_p_r   <= s8_p_r;
      s9_k1_r  <= mul32(s8_sq_r, POLY_K1);
      s9_k2_r  <= s8_k2_r;
      s9_t_r   <= s8_t_r;
      s9_flt_r <= s8_flt_r;
    end
  end

  // output register
  logic [31:0] pf;
  logic [19:0] psat;
  out_word_t   res;
  always_comb begin
    pf = s9_p_r + asr32(asr32(s9_k1_r, 5'd16) + asr32(s9_k2_r, 5'd16) + POLY_K3, 5'd4);
    if (pf[31]) psat = '0;
    else if (pf > {12'd0, P_MAX}) psat = P_MAX;
    else psat = pf[19:0];
    res.temperature_tenths = s9_flt_r ? 16'sd0 : s9_t_r;
    res.pressure_pa        = s9_flt_r ? 20'd0 : psat;
    res.divide_fault       = s9_flt_r;
  end

  logic      out_v_r;
  out_word_t out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= s9_v_r;
    if (adv) out_r <= res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_fault |-> out_data.pressure_pa == 20'd0 &&
    out_data.temperature_tenths == 16'sd0)
    else $error("fault word carries nonzero results");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

@@ bench/tb_baro_sensor_compensation_top.sv @@
// testbench for the pressure sensor compensation block: directed and random words against a predictor
module tb_baro_sensor_compensation_top;
  import bsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 74;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [47:0] grp_a, grp_b;
  logic [31:0] grp_c, grp_d;
  logic [1:0] oss_set;

  out_word_t expected_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_long = 1'b0;
  bit timed_out = 1'b0;

  baro_sensor_compensation_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] sar(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] lo_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  function automatic out_word_t compensate(input in_word_t w);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, dv, b5, b6, b6sq, b3, b4, b7, p;
    longint t, ps;
    out_word_t r;
    ac1 = ext16(grp_a[47:32]); ac2 = ext16(grp_a[31:16]); ac3 = ext16(grp_a[15:0]);
    ac4 = {16'd0, grp_b[47:32]}; ac5 = {16'd0, grp_b[31:16]}; ac6 = {16'd0, grp_b[15:0]};
    b1 = ext16(grp_c[31:16]); b2 = ext16(grp_c[15:0]);
    mc = ext16(grp_d[31:16]); md = ext16(grp_d[15:0]);
    r = '0;
    ut = {16'd0, w.raw_temperature};
    up = {8'd0, w.raw_pressure_bytes} >> (8 - oss_set);
    x1 = sar(lo_mul(ut - ac6, ac5), 15);
    dv = x1 + md;
    if (dv == 0) begin
      r.divide_fault = 1'b1;
      return r;
    end
    x2 = 32'($signed(lo_mul(mc, 32'd2048)) / $signed(dv));
    b5 = x1 + x2;
    t = longint'($signed(sar(b5 + 32'd8, 4)));
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    b6 = b5 - 32'd4000;
    b6sq = sar(lo_mul(b6, b6), 12);
    x1 = sar(lo_mul(b2, b6sq), 11);
    x2 = sar(lo_mul(ac2, b6), 11);
    x3 = x1 + x2;
    b3 = sar(((lo_mul(ac1, 32'd4) + x3) << oss_set) + 32'd2, 2);
    x1 = sar(lo_mul(ac3, b6), 13);
    x2 = sar(lo_mul(b1, b6sq), 16);
    x3 = sar(x1 + x2 + 32'd2, 2);
    b4 = lo_mul(ac4, x3 + 32'd32768) >> 15;
    if (b4 == 0) begin
      r.divide_fault = 1'b1;
      return r;
    end
    b7 = lo_mul(up - b3, 32'd50000 >> oss_set);
    if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = sar(p, 8);
    x1 = lo_mul(x1, x1);
    x1 = sar(lo_mul(x1, 32'd3038), 16);
    x2 = sar(lo_mul(32'hFFFF_E343, p), 16);
    p = p + sar(x1 + x2 + 32'd3791, 4);
    ps = longint'($signed(p));
    if (ps < 0) ps = 0;
    if (ps > 1048575) ps = 1048575;
    r.temperature_tenths = 16'(t);
    r.pressure_pa = 20'(ps);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        e = expected_q.pop_front();
        if (out_data.temperature_tenths !== e.temperature_tenths ||
            out_data.pressure_pa !== e.pressure_pa ||
            out_data.divide_fault !== e.divide_fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp t=%0d p=%0d f=%0d got t=%0d p=%0d f=%0d",
                     e.temperature_tenths, e.pressure_pa, e.divide_fault,
                     out_data.temperature_tenths, out_data.pressure_pa,
                     out_data.divide_fault);
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_long) out_stall <= 1'b1;
    else if (r < 40) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // long hold-off counted here
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_long = 1'b1;
    repeat (300) @(posedge clk);
    hold_long = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (!in_valid && expected_q.size() == 0))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_COEFF_A: grp_a = val;
      REG_COEFF_B: grp_b = val;
      REG_COEFF_C: grp_c = val[31:0];
      REG_COEFF_D: grp_d = val[31:0];
      REG_OSS: oss_set = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_coeffs(input logic [47:0] a, input logic [47:0] b,
                            input logic [31:0] c, input logic [31:0] d,
                            input logic [1:0] o);
    write_reg(REG_COEFF_A, a);
    write_reg(REG_COEFF_B, b);
    write_reg(REG_COEFF_C, {16'd0, c});
    write_reg(REG_COEFF_D, {16'd0, d});
    write_reg(REG_OSS, {46'd0, o});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input logic [15:0] ut, input logic [23:0] up);
    in_word_t w;
    w.raw_temperature = ut;
    w.raw_pressure_bytes = up;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(compensate(w));
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic random_burst(input int n, input bit typical);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = hold_long ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if (typical) send_word(16'($urandom_range(20000, 35000)),
                             24'($urandom_range(6000000, 12000000)));
      else send_word(16'($urandom), 24'($urandom));
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_directed();
    set_coeffs({16'sd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
               {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, 2'd0);
    send_word(16'd27898, 24'd23843 << 8);
    send_word(16'd0, 24'd0);
    send_word(16'hFFFF, 24'hFFFFFF);
    send_word(16'hFFFF, 24'd0);
    send_word(16'd0, 24'hFFFFFF);
    send_word(16'h5555, 24'hAAAAAA);
    send_word(16'hAAAA, 24'h555555);
    in_valid <= 1'b0;
    drain();
    // zero coefficients: temperature divisor zero
    set_coeffs('0, '0, '0, '0, 2'd3);
    send_word(16'd1234, 24'd99999);
    in_valid <= 1'b0;
    drain();
    // ac4 zero gives a zero pressure divisor
    set_coeffs({16'sd408, -16'sd72, -16'sd14383}, {16'd0, 16'd32757, 16'd23153},
               {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, 2'd3);
    send_word(16'd27898, 24'hFFFFFF);
    in_valid <= 1'b0;
    drain();
    // extreme coefficients for saturation and wrap
    set_coeffs(48'h7FFF_8000_7FFF, 48'hFFFF_FFFF_0000, 32'h8000_7FFF, 32'h7FFF_0001, 2'd3);
    send_word(16'hFFFF, 24'hFFFFFF);
    send_word(16'd0, 24'd0);
    send_word(16'h8000, 24'h800000);
    in_valid <= 1'b0;
    drain();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0)
        set_coeffs({16'($urandom_range(0, 2000)), -16'sd72, -16'($urandom_range(10000, 16000))},
                   {16'($urandom_range(30000, 34000)), 16'($urandom_range(24000, 33000)),
                    16'($urandom_range(15000, 25000))},
                   {16'($urandom_range(5000, 7000)), 16'($urandom_range(0, 50))},
                   {-16'($urandom_range(8000, 12000)), 16'($urandom_range(2000, 3000))},
                   2'(ph / 2 + ph % 2));
      else
        set_coeffs({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                   32'($urandom), 32'($urandom), 2'($urandom));
      random_burst(80, ph % 2 == 0);
      drain();
    end
  endtask

  task automatic test_backpressure();
    set_coeffs({16'sd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
               {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, 2'd1);
    hold_req = 1'b1;
    wait (hold_long);
    random_burst(120, 1'b1);
    drain();
  endtask

  initial begin
    grp_a = '0; grp_b = '0; grp_c = '0; grp_d = '0; oss_set = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_settings();
    drain();
    if (mismatches == 0 && expected_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/bsc_pkg.sv
src/bsc_divider.sv
src/baro_sensor_compensation_top.sv
bench/tb_baro_sensor_compensation_top.sv
